/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the soft limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tsl_pkg.sv */
// Shared constants and types of the tanh soft limiter.
`default_nettype none

package tsl_pkg;

    // default table size (steps over [0, 8])
    localparam int TSL_TABLE_ENTRIES = 256;

    // pipeline stages, in the order an item passes them
    localparam int STG_PROD   = 0;
    localparam int STG_SCALE  = 1;
    localparam int STG_EST    = 2;
    localparam int STG_POS    = 3;
    localparam int STG_ROM    = 4;
    localparam int STG_DIFF   = 5;
    localparam int STG_MUL    = 6;
    localparam int STG_SUM    = 7;
    localparam int STG_ROUND  = 8;
    localparam int STG_OUT    = 9;
    localparam int TSL_STAGES = 10;

    // interpolated magnitude in Q47, clamped at zero
    localparam int YMAG_W = 52;

    localparam logic [15:0] DEFAULT_GAIN = 16'd8192;
    localparam logic [14:0] FULL_SCALE   = 15'd32767;

    // per-stage advance enables and valid bits
    typedef struct packed {
        logic [TSL_STAGES-1:0] en;
        logic [TSL_STAGES-1:0] vld;
    } stage_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/tanh_soft_limiter.sv */
// Top level of the tanh soft limiter: gain register, output scaling and sign.
// Soft limiter for signed 16-bit PCM: each sample s becomes the rounded value of
// 32767*tanh(G*s/32767), where G is the gain register in unsigned Q6.10 (zero selects
// 8.0; reset value 8.0). The block is a ten-stage pipeline with a valid bit per stage:
// it takes one sample every clock cycle while the result side does not stall. A stall
// holds only the stages that are full, so empty stages keep taking samples. The tanh
// table of TABLE_ENTRIES + 1 points is constant logic read at three neighbouring
// addresses in one stage; there is no fill or clearing pass after reset. Write the
// gain only while no sample is in flight.
`default_nettype none
`include "assert_macros.svh"

module tanh_soft_limiter #(
    parameter int TABLE_ENTRIES = tsl_pkg::TSL_TABLE_ENTRIES
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire signed [15:0]  s_sample_in,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [15:0] m_sample_out,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [15:0]         cfg_gain_q6_10
);
    import tsl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES + 1);

    stage_ctl_t           ctl;
    logic [15:0]          gain_reg;
    logic [15:0]          gain_next;

    logic                 pos_neg;
    logic                 pos_sat;
    logic [IW-1:0]        pos_idx;
    logic [15:0]          pos_frac;

    logic                 itp_neg;
    logic                 itp_sat;
    logic [YMAG_W-1:0]    itp_ymag;

    logic [67:0]          scaled_w;
    logic                 neg9_reg;
    logic                 sat9_reg;
    logic [20:0]          m9_reg;

    logic [14:0]          mag_w;
    logic [15:0]          mag_ext_w;
    logic signed [15:0]   out_reg;

    // gain register; always ready for a write
    assign cfg_ready = 1'b1;
    assign gain_next = cfg_valid ? cfg_gain_q6_10 : gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= DEFAULT_GAIN;
        end else begin
            gain_reg <= gain_next;
        end
    end

    tsl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .ctl       (ctl)
    );

    tsl_position #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sample_in (s_sample_in),
        .gain      (gain_reg),
        .neg_out   (pos_neg),
        .sat_out   (pos_sat),
        .idx_out   (pos_idx),
        .frac_out  (pos_frac)
    );

    tsl_interp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_interp (
        .aclk     (aclk),
        .ctl      (ctl),
        .neg_in   (pos_neg),
        .sat_in   (pos_sat),
        .idx_in   (pos_idx),
        .frac_in  (pos_frac),
        .neg_out  (itp_neg),
        .sat_out  (itp_sat),
        .ymag_out (itp_ymag)
    );

    // scale Q47 by full scale and round: (32767*Y + 2^46) >> 47
    assign scaled_w = (68'(itp_ymag) << 15) + (68'd1 << 46) - 68'(itp_ymag);

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_ROUND]) begin
            neg9_reg <= itp_neg;
            sat9_reg <= itp_sat;
            m9_reg   <= scaled_w[67:47];
        end
    end

    // clamp to full scale and apply the sign
    assign mag_w     = (sat9_reg || (m9_reg > 21'(FULL_SCALE))) ? FULL_SCALE : m9_reg[14:0];
    assign mag_ext_w = {1'b0, mag_w};

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_OUT]) begin
            out_reg <= $signed(neg9_reg ? (16'd0 - mag_ext_w) : mag_ext_w);
        end
    end

    assign m_sample_out = out_reg;

    // full scale is symmetric: the most negative code never leaves the block
    `TSL_ASSERT_IMP(a_no_min_out, m_valid, (m_sample_out != -16'sd32768),
        "tanh_soft_limiter: result below negative full scale")

    // a saturated item leaves the rounding stage at full scale
    `TSL_ASSERT_IMP(a_sat_full, ctl.vld[STG_ROUND] && sat9_reg, (mag_w == FULL_SCALE),
        "tanh_soft_limiter: saturated item not at full scale")

endmodule

`default_nettype wire

/* hw/rtl/tsl_ctrl.sv */
// Valid/ready control of the limiter pipeline: stage valid bits and advance enables.
`default_nettype none
`include "assert_macros.svh"

module tsl_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output tsl_pkg::stage_ctl_t ctl
);
    import tsl_pkg::*;

    localparam int LAST = TSL_STAGES - 1;

    logic [TSL_STAGES-1:0] vld_reg;
    logic [TSL_STAGES-1:0] vld_next;
    logic [TSL_STAGES-1:0] en;
    logic                  in_acc;
    logic                  out_acc;

    // a stage advances when it is empty or its successor advances
    always_comb begin
        en[LAST] = !vld_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    // move valid bits along with the data
    always_comb begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < TSL_STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[LAST];
    assign in_acc    = in_valid && en[0];
    assign out_acc   = vld_reg[LAST] && out_ready;
    assign ctl.en    = en;
    assign ctl.vld   = vld_reg;

    // items in flight change only by what enters and what leaves
    `TSL_ASSERT_NEXT(a_item_count, 1'b1,
        ($countones(vld_reg) == $past($countones(vld_reg)) + $past(int'(in_acc))
            - $past(int'(out_acc))), "tsl_ctrl: item lost or duplicated")

    // a stalled stage keeps its valid bit
    `TSL_ASSERT_NEXT(a_stall_hold, 1'b1,
        (((vld_reg ^ $past(vld_reg)) & ~$past(en)) == '0), "tsl_ctrl: stalled stage changed")

endmodule

`default_nettype wire

/* hw/rtl/tsl_position.sv */
// Front stages: magnitude times gain, scaling to table steps, division by full scale.
`default_nettype none
`include "assert_macros.svh"

module tsl_position #(
    parameter int TABLE_ENTRIES = tsl_pkg::TSL_TABLE_ENTRIES
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  var tsl_pkg::stage_ctl_t                  ctl,
    input  wire signed [15:0]                        sample_in,
    input  wire        [15:0]                        gain,
    output logic                                     neg_out,
    output logic                                     sat_out,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]       idx_out,
    output logic [15:0]                              frac_out
);
    import tsl_pkg::*;

    localparam int MULK  = TABLE_ENTRIES * 8;
    localparam int KW    = $clog2(MULK + 1);
    localparam int XW    = 32 + KW + 1;
    localparam int QW    = XW - 14;
    localparam int IW    = $clog2(TABLE_ENTRIES + 1);
    localparam int NTERM = (XW - 1) / 15;

    localparam logic [KW-1:0]   MULK_C     = KW'(MULK);
    localparam logic [XW-1:0]   ROUND_BIAS = XW'(16383);
    localparam logic [16:0]     DIV1       = 17'd32767;
    localparam logic [16:0]     DIV2       = 17'd65534;
    localparam logic [16:0]     DIV3       = 17'd98301;
    localparam logic [16:0]     REM_LIMIT  = 17'd131068;
    localparam logic [QW-17:0]  IDX_LIMIT  = (QW-16)'(TABLE_ENTRIES);

    logic [15:0]    raw_w;
    logic [15:0]    mag_w;
    logic [15:0]    gain_w;

    logic           neg1_reg;
    logic [31:0]    prod_reg;
    logic           neg2_reg;
    logic [XW-1:0]  x_reg;
    logic           neg3_reg;
    logic [QW-1:0]  est_reg;
    logic [16:0]    xlo_reg;
    logic [QW-1:0]  est_w;

    logic [16:0]    rem_w;
    logic [1:0]     adj_w;
    logic [QW-1:0]  q_w;
    logic           sat_w;

    logic           neg4_reg;
    logic           sat4_reg;
    logic [IW-1:0]  idx4_reg;
    logic [15:0]    frac4_reg;

    // take the magnitude and the effective gain
    assign raw_w  = sample_in;
    assign mag_w  = raw_w[15] ? (16'd0 - raw_w) : raw_w;
    assign gain_w = (gain == '0) ? DEFAULT_GAIN : gain;

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_PROD]) begin
            neg1_reg <= raw_w[15];
            prod_reg <= 32'(gain_w) * 32'(mag_w);
        end
    end

    // scale to Q16 table steps and add the rounding bias
    always_ff @(posedge aclk) begin
        if (ctl.en[STG_SCALE]) begin
            neg2_reg <= neg1_reg;
            x_reg    <= XW'(prod_reg) * XW'(MULK_C) + ROUND_BIAS;
        end
    end

    // estimate the quotient by 2^15-1 as a sum of shifted copies
    always_comb begin
        est_w = '0;
        for (int k = 1; k <= NTERM; k++) begin
            est_w = est_w + QW'(x_reg >> (15 * k));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_EST]) begin
            neg3_reg <= neg2_reg;
            est_reg  <= est_w;
            xlo_reg  <= x_reg[16:0];
        end
    end

    // remainder is below four divisors, so low bits suffice
    assign rem_w = xlo_reg - {est_reg[1:0], 15'd0} + est_reg[16:0];
    assign adj_w = 2'(rem_w >= DIV1) + 2'(rem_w >= DIV2) + 2'(rem_w >= DIV3);
    assign q_w   = est_reg + QW'(adj_w);
    assign sat_w = q_w[QW-1:16] >= IDX_LIMIT;

    // split into table index and fraction; park the index at zero when saturated
    always_ff @(posedge aclk) begin
        if (ctl.en[STG_POS]) begin
            neg4_reg  <= neg3_reg;
            sat4_reg  <= sat_w;
            idx4_reg  <= sat_w ? '0 : q_w[16+IW-1:16];
            frac4_reg <= q_w[15:0];
        end
    end

    assign neg_out  = neg4_reg;
    assign sat_out  = sat4_reg;
    assign idx_out  = idx4_reg;
    assign frac_out = frac4_reg;

    // the shift-sum estimate must be within three of the true quotient
    `TSL_ASSERT_IMP(a_rem_bound, ctl.vld[STG_EST], (rem_w < REM_LIMIT),
        "tsl_position: quotient estimate out of range")

endmodule

`default_nettype wire

/* hw/rtl/tsl_interp.sv */
// Middle stages: tanh table lookup and second-order interpolation in Q47.
`default_nettype none

module tsl_interp #(
    parameter int TABLE_ENTRIES = tsl_pkg::TSL_TABLE_ENTRIES
) (
    input  wire                                  aclk,
    input  var tsl_pkg::stage_ctl_t              ctl,
    input  wire                                  neg_in,
    input  wire                                  sat_in,
    input  wire [$clog2(TABLE_ENTRIES+1)-1:0]    idx_in,
    input  wire [15:0]                           frac_in,
    output logic                                 neg_out,
    output logic                                 sat_out,
    output logic [tsl_pkg::YMAG_W-1:0]           ymag_out
);
    import tsl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
    // exponent step 16/N in Q32, rounded
    localparam logic [63:0] STEP_U  =
        ((64'd1 << 36) + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);

    typedef logic signed [31:0] rom_word_t;
    typedef rom_word_t rom_arr_t [TABLE_ENTRIES+1];

    // restoring long division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8k/N) in Q2.30 as (1 - E) / (1 + E), E = exp(-16k/N) in Q32
    function automatic rom_arr_t build_rom();
        rom_arr_t    rom;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] base;
        logic [63:0] num;
        logic [63:0] den;
        sum  = ONE_Q32;
        term = ONE_Q32;
        e    = ONE_Q32;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64((term * STEP_U) >> 32, 64'(k));
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        base = sum;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            num    = ONE_Q32 - e;
            den    = ONE_Q32 + e;
            rom[i] = 32'(udiv64((num << 30) + (den >> 1), den));
            e      = (e * base + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam rom_arr_t TANH_ROM = build_rom();

    logic [IW-1:0]         addr_hi_w;
    logic [IW-1:0]         addr_lo_w;
    logic                  idx_zero_w;
    rom_word_t             ylo_w;

    logic                  neg5_reg;
    logic                  sat5_reg;
    rom_word_t             y0_5_reg;
    rom_word_t             y1_5_reg;
    rom_word_t             ym_5_reg;
    logic [15:0]           t5_reg;
    logic [15:0]           tt5_reg;
    logic [31:0]           tsq_w;

    logic                  neg6_reg;
    logic                  sat6_reg;
    rom_word_t             y0_6_reg;
    logic [15:0]           t6_reg;
    logic [15:0]           tt6_reg;
    logic signed [33:0]    d1_reg;
    logic signed [33:0]    d2_reg;

    logic signed [16:0]    t_s_w;
    logic signed [16:0]    tt_s_w;

    logic                  neg7_reg;
    logic                  sat7_reg;
    rom_word_t             y0_7_reg;
    logic signed [50:0]    p1_reg;
    logic signed [50:0]    p2_reg;

    logic signed [52:0]    ysum_w;

    logic                  neg8_reg;
    logic                  sat8_reg;
    logic [YMAG_W-1:0]     y8_reg;

    // neighbour addresses; below zero use the mirrored first point
    assign idx_zero_w = (idx_in == '0);
    assign addr_hi_w  = idx_in + IW'(1);
    assign addr_lo_w  = idx_zero_w ? IW'(1) : (idx_in - IW'(1));
    assign ylo_w      = TANH_ROM[addr_lo_w];
    assign tsq_w      = 32'(frac_in) * 32'(frac_in);

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_ROM]) begin
            neg5_reg <= neg_in;
            sat5_reg <= sat_in;
            y0_5_reg <= TANH_ROM[idx_in];
            y1_5_reg <= TANH_ROM[addr_hi_w];
            ym_5_reg <= idx_zero_w ? (32'sd0 - ylo_w) : ylo_w;
            t5_reg   <= frac_in;
            tt5_reg  <= tsq_w[31:16];
        end
    end

    // first and second differences
    always_ff @(posedge aclk) begin
        if (ctl.en[STG_DIFF]) begin
            neg6_reg <= neg5_reg;
            sat6_reg <= sat5_reg;
            y0_6_reg <= y0_5_reg;
            t6_reg   <= t5_reg;
            tt6_reg  <= tt5_reg;
            d1_reg   <= 34'(y1_5_reg) - 34'(ym_5_reg);
            d2_reg   <= 34'(y1_5_reg) - (34'(y0_5_reg) <<< 1) + 34'(ym_5_reg);
        end
    end

    // weight the differences by the fraction and its square
    assign t_s_w  = $signed({1'b0, t6_reg});
    assign tt_s_w = $signed({1'b0, tt6_reg});

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_MUL]) begin
            neg7_reg <= neg6_reg;
            sat7_reg <= sat6_reg;
            y0_7_reg <= y0_6_reg;
            p1_reg   <= 51'(t_s_w) * 51'(d1_reg);
            p2_reg   <= 51'(tt_s_w) * 51'(d2_reg);
        end
    end

    // sum in Q47 and clamp below at zero
    assign ysum_w = (53'(y0_7_reg) <<< 17) + 53'(p1_reg) + 53'(p2_reg);

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_SUM]) begin
            neg8_reg <= neg7_reg;
            sat8_reg <= sat7_reg;
            y8_reg   <= ysum_w[52] ? '0 : ysum_w[YMAG_W-1:0];
        end
    end

    assign neg_out  = neg8_reg;
    assign sat_out  = sat8_reg;
    assign ymag_out = y8_reg;

endmodule

`default_nettype wire
